// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the setpoint frame receiver.
// No dependencies; pulled in by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define SSFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/ssfr_pkg.sv =====
// Shared constants and types of the servo setpoint frame receiver.
// No dependencies; imported by ssfr_frame_chk and the top level.
package ssfr_pkg;

  localparam int BYTE_W       = 8;
  localparam int CHAN_W       = 16;
  localparam int SUM_W        = 32;
  localparam int OUT_PWM_W    = 15;
  localparam int CFG_W        = 15;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_ZOOM     = 8;
  localparam int PAY_LEN      = 10;
  localparam int PAY_BUF_LEN  = PAY_LEN - 1;
  localparam int PAY_CNT_W    = 4;
  localparam int WIN_W        = 40;
  localparam int PWM_BITS_DEF = 15;
  localparam int PWM_MAX_W    = 16;

  localparam logic [WIN_W-1:0] MARKER = 40'h53_54_41_52_54;  // "START"

  localparam logic [PWM_MAX_W-1:0] POS_RESET = 16'd4400;

  localparam logic [PWM_MAX_W-1:0] ZOOM_RESET [NUM_ZOOM] = '{
    16'd2220, 16'd2472, 16'd2630, 16'd2855,
    16'd3253, 16'd3624, 16'd3975, 16'd4400
  };

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic sum_ok;
    logic in_table;
  } chk_t;

  typedef struct packed {
    logic [OUT_PWM_W-1:0] position;
    logic [OUT_PWM_W-1:0] setpoint;
    chan_t                chan_a;
    chan_t                chan_b;
    chan_t                chan_c;
    logic                 frame_done;
    logic                 sum_ok;
    logic                 target_taken;
  } res_t;

endpackage

// ===== hdl/ssfr_frame_chk.sv =====
// Payload decode: splits the ten payload bytes into channels and checksum,
// checks the sum and matches channel 0 against the zoom table. Uses ssfr_pkg.
module ssfr_frame_chk #(
  parameter int PWM_BITS = ssfr_pkg::PWM_BITS_DEF
) (
  input  ssfr_pkg::byte_t       pay_bytes [ssfr_pkg::PAY_BUF_LEN],
  input  ssfr_pkg::byte_t       last_byte,
  input  logic [PWM_BITS-1:0]   zoom [ssfr_pkg::NUM_ZOOM],
  output ssfr_pkg::chan_t       chan0,
  output ssfr_pkg::chan_t       chan1,
  output ssfr_pkg::chan_t       chan2,
  output ssfr_pkg::chk_t        chk
);
  import ssfr_pkg::*;

  logic [SUM_W-1:0]    rx_sum;
  logic [CHAN_W+1:0]   chan_sum;
  logic [NUM_ZOOM-1:0] hit;

  assign chan0  = {pay_bytes[1], pay_bytes[0]};
  assign chan1  = {pay_bytes[3], pay_bytes[2]};
  assign chan2  = {pay_bytes[5], pay_bytes[4]};
  assign rx_sum = {last_byte, pay_bytes[8], pay_bytes[7], pay_bytes[6]};

  assign chan_sum = (CHAN_W+2)'(chan0) + (CHAN_W+2)'(chan1) + (CHAN_W+2)'(chan2);

  always_comb begin
    for (int i = 0; i < NUM_ZOOM; i++) begin
      hit[i] = (CHAN_W'(zoom[i]) == chan0);
    end
  end

  assign chk.sum_ok   = (rx_sum == SUM_W'(chan_sum));
  assign chk.in_table = |hit;

endmodule

// ===== hdl/servo_setpoint_frame_receiver.sv =====
// Servo setpoint frame receiver: takes one item (serial byte or slew tick) per
// clock while in_stall is low, and returns one result per item, registered in the
// output stages. All decoding sits between the state registers and a two-deep output
// (result register plus skid stage), so the input keeps flowing while a result
// waits; in_stall rises only once both output stages are full. Zoom table
// writes via cfg_we/cfg_idx/cfg_wdata take effect at the next clock.
// Uses ssfr_pkg, ssfr_frame_chk and assert_macros.svh.
`include "assert_macros.svh"

module servo_setpoint_frame_receiver #(
  parameter int PWM_BITS = ssfr_pkg::PWM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [ssfr_pkg::BYTE_W-1:0]          in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ssfr_pkg::OUT_PWM_W-1:0]       out_position,
  output logic [ssfr_pkg::OUT_PWM_W-1:0]       out_setpoint,
  output logic [ssfr_pkg::CHAN_W-1:0]          out_chan_a,
  output logic [ssfr_pkg::CHAN_W-1:0]          out_chan_b,
  output logic [ssfr_pkg::CHAN_W-1:0]          out_chan_c,
  output logic                                 out_frame_done,
  output logic                                 out_sum_ok,
  output logic                                 out_target_taken,
  input  logic                                 cfg_we,
  input  logic [ssfr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ssfr_pkg::CFG_W-1:0]           cfg_wdata
);
  import ssfr_pkg::*;

  logic [PWM_BITS-1:0]  zoom_r [NUM_ZOOM];
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic                 in_pay_r, in_pay_nxt;
  logic [PAY_CNT_W-1:0] cnt_r, cnt_nxt;
  byte_t                pay_r [PAY_BUF_LEN];
  chan_t                held_r [3];
  chan_t                held_nxt [3];
  logic [PWM_BITS-1:0]  target_r, target_nxt;
  logic [PWM_BITS-1:0]  pwm_r, pwm_nxt;

  logic                 out_v_r, skid_v_r;
  res_t                 out_r, skid_r, res;

  logic                 acc, byte_acc, last_pay;
  logic [WIN_W-1:0]     win_shift;
  chan_t                c0, c1, c2;
  chk_t                 chk;
  logic [PWM_MAX_W-1:0] cfg_wide;

  assign in_stall  = skid_v_r;
  assign acc       = in_valid && !in_stall;
  assign byte_acc  = acc && (in_op == OP_BYTE);
  assign last_pay  = in_pay_r && (cnt_r == PAY_CNT_W'(PAY_BUF_LEN));
  assign win_shift = {win_r[WIN_W-BYTE_W-1:0], in_rx_byte};
  assign cfg_wide  = PWM_MAX_W'(cfg_wdata);

  ssfr_frame_chk #(
    .PWM_BITS (PWM_BITS)
  ) u_chk (
    .pay_bytes (pay_r),
    .last_byte (in_rx_byte),
    .zoom      (zoom_r),
    .chan0     (c0),
    .chan1     (c1),
    .chan2     (c2),
    .chk       (chk)
  );

  always_comb begin
    win_nxt    = win_r;
    in_pay_nxt = in_pay_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    target_nxt = target_r;
    pwm_nxt    = pwm_r;
    res.frame_done   = 1'b0;
    res.sum_ok       = 1'b0;
    res.target_taken = 1'b0;
    if (in_op == OP_BYTE) begin
      if (in_pay_r) begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_pay) begin
          in_pay_nxt     = 1'b0;
          cnt_nxt        = '0;
          res.frame_done = 1'b1;
          if (chk.sum_ok) begin
            res.sum_ok  = 1'b1;
            held_nxt[0] = c0;
            held_nxt[1] = c1;
            held_nxt[2] = c2;
            if (chk.in_table && (c0 != CHAN_W'(target_r))) begin
              target_nxt       = c0[PWM_BITS-1:0];
              res.target_taken = 1'b1;
            end
          end
        end
      end else begin
        win_nxt = win_shift;
        if (win_shift == MARKER) begin
          win_nxt    = '0;
          in_pay_nxt = 1'b1;
          cnt_nxt    = '0;
        end
      end
    end else begin
      if (target_r > pwm_r) begin
        pwm_nxt = pwm_r + 1'b1;
      end else if (target_r < pwm_r) begin
        pwm_nxt = pwm_r - 1'b1;
      end
    end
    res.position = OUT_PWM_W'(PWM_MAX_W'(pwm_nxt));
    res.setpoint = OUT_PWM_W'(PWM_MAX_W'(target_nxt));
    res.chan_a   = held_nxt[0];
    res.chan_b   = held_nxt[1];
    res.chan_c   = held_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ZOOM; i++) begin
        zoom_r[i] <= ZOOM_RESET[i][PWM_BITS-1:0];
      end
    end else if (cfg_we) begin
      zoom_r[cfg_idx] <= cfg_wide[PWM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      in_pay_r <= 1'b0;
      cnt_r    <= '0;
      held_r   <= '{default: '0};
      target_r <= POS_RESET[PWM_BITS-1:0];
      pwm_r    <= POS_RESET[PWM_BITS-1:0];
    end else if (acc) begin
      win_r    <= win_nxt;
      in_pay_r <= in_pay_nxt;
      cnt_r    <= cnt_nxt;
      held_r   <= held_nxt;
      target_r <= target_nxt;
      pwm_r    <= pwm_nxt;
    end
  end

  // payload bytes 0..8; byte 9 is used live
  for (genvar k = 0; k < PAY_BUF_LEN; k++) begin : g_pay
    always_ff @(posedge clk) begin
      if (byte_acc && in_pay_r && (cnt_r == PAY_CNT_W'(k))) begin
        pay_r[k] <= in_rx_byte;
      end
    end
  end

  // result register plus skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || acc;
      skid_v_r <= 1'b0;
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_position     = out_r.position;
  assign out_setpoint     = out_r.setpoint;
  assign out_chan_a       = out_r.chan_a;
  assign out_chan_b       = out_r.chan_b;
  assign out_chan_c       = out_r.chan_c;
  assign out_frame_done   = out_r.frame_done;
  assign out_sum_ok       = out_r.sum_ok;
  assign out_target_taken = out_r.target_taken;

  `SSFR_ASSERT(a_skid_behind_out, !skid_v_r || out_v_r, "skid item without result item")
  `SSFR_ASSERT(a_cnt_range,
    !in_pay_r || cnt_r <= PAY_CNT_W'(PAY_BUF_LEN), "payload count overrun")
  `SSFR_ASSERT(a_frame_end,
    byte_acc && last_pay |=> !in_pay_r && cnt_r == '0, "frame not closed")
  `SSFR_ASSERT(a_taken_flags,
    out_v_r && out_r.target_taken |-> out_r.sum_ok && out_r.frame_done,
    "setpoint taken without good frame")
  `SSFR_ASSERT(a_tick_step,
    acc && in_op == OP_TICK |=> pwm_r == $past(pwm_r) ||
      pwm_r == $past(pwm_r) + 1'b1 || pwm_r == $past(pwm_r) - 1'b1,
    "position moved more than one step")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for servo_setpoint_frame_receiver: marker search, frame checksum,
// zoom table match and slew ticks, predicted per item and compared field by field.
// Depends on ssfr_pkg and the receiver RTL; needs no other files.
`timescale 1ns / 100ps

module testbench;
  import ssfr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_BYTE;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_PWM_W-1:0] out_position;
  logic [OUT_PWM_W-1:0] out_setpoint;
  logic [CHAN_W-1:0] out_chan_a;
  logic [CHAN_W-1:0] out_chan_b;
  logic [CHAN_W-1:0] out_chan_c;
  logic out_frame_done;
  logic out_sum_ok;
  logic out_target_taken;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  servo_setpoint_frame_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_position(out_position), .out_setpoint(out_setpoint),
    .out_chan_a(out_chan_a), .out_chan_b(out_chan_b), .out_chan_c(out_chan_c),
    .out_frame_done(out_frame_done), .out_sum_ok(out_sum_ok),
    .out_target_taken(out_target_taken),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver-side model state
  logic [WIN_W-1:0] marker_win;
  bit collecting;
  int unsigned pay_idx;
  byte_t pay_bytes [PAY_LEN];
  chan_t held [3];
  logic [CFG_W-1:0] zoom_tab [NUM_ZOOM];
  logic [CFG_W-1:0] zoom_next [NUM_ZOOM];
  logic [OUT_PWM_W-1:0] aim_pwm;
  logic [OUT_PWM_W-1:0] slew_pwm;

  res_t status_q [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int frame_tick_pct = 0;
  int hold_len = 0;
  int hold_left = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;

  function automatic res_t servo_track(input logic op, input byte_t b);
    res_t r;
    logic [CHAN_W-1:0] c0, c1, c2;
    logic [SUM_W-1:0] sum;
    bit hit;
    r = '0;
    if (op == OP_BYTE) begin
      if (collecting) begin
        pay_bytes[pay_idx] = b;
        pay_idx++;
        if (pay_idx == PAY_LEN) begin
          collecting = 0;
          pay_idx = 0;
          r.frame_done = 1'b1;
          c0 = {pay_bytes[1], pay_bytes[0]};
          c1 = {pay_bytes[3], pay_bytes[2]};
          c2 = {pay_bytes[5], pay_bytes[4]};
          sum = {pay_bytes[9], pay_bytes[8], pay_bytes[7], pay_bytes[6]};
          if (sum == {16'd0, c0} + {16'd0, c1} + {16'd0, c2}) begin
            r.sum_ok = 1'b1;
            held[0] = c0;
            held[1] = c1;
            held[2] = c2;
            hit = 0;
            for (int i = 0; i < NUM_ZOOM; i++)
              if ({1'b0, zoom_tab[i]} == c0) hit = 1;
            if (hit && c0 != {1'b0, aim_pwm}) begin
              aim_pwm = c0[OUT_PWM_W-1:0];
              r.target_taken = 1'b1;
            end
          end
        end
      end else begin
        marker_win = {marker_win[WIN_W-9:0], b};
        if (marker_win == MARKER) begin
          marker_win = '0;
          collecting = 1;
          pay_idx = 0;
        end
      end
    end else begin
      if (aim_pwm > slew_pwm) slew_pwm++;
      else if (aim_pwm < slew_pwm) slew_pwm--;
    end
    r.position = slew_pwm;
    r.setpoint = aim_pwm;
    r.chan_a = held[0];
    r.chan_b = held[1];
    r.chan_c = held[2];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        flag_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = status_q.pop_front();
        if (out_position != want.position)
          flag_mismatch("position", out_position, want.position);
        if (out_setpoint != want.setpoint)
          flag_mismatch("setpoint", out_setpoint, want.setpoint);
        if (out_chan_a != want.chan_a) flag_mismatch("chan_a", out_chan_a, want.chan_a);
        if (out_chan_b != want.chan_b) flag_mismatch("chan_b", out_chan_b, want.chan_b);
        if (out_chan_c != want.chan_c) flag_mismatch("chan_c", out_chan_c, want.chan_c);
        if (out_frame_done != want.frame_done)
          flag_mismatch("frame_done", out_frame_done, want.frame_done);
        if (out_sum_ok != want.sum_ok) flag_mismatch("sum_ok", out_sum_ok, want.sum_ok);
        if (out_target_taken != want.target_taken)
          flag_mismatch("target_taken", out_target_taken, want.target_taken);
      end
      results_seen++;
    end
  end

  // output stall: random, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic op, input byte_t b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_q.push_back(servo_track(op, b));
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_zoom_table();
    wait_drain();
    for (int i = 0; i < NUM_ZOOM; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_wdata <= zoom_next[i];
      @(posedge clk);
      zoom_tab[i] = zoom_next[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_setpoint_frame(input chan_t c0, input chan_t c1, input chan_t c2,
                                     input logic [SUM_W-1:0] sum);
    byte_t frm [15];
    for (int i = 0; i < 5; i++) frm[i] = MARKER[WIN_W-1-8*i -: 8];
    frm[5] = c0[7:0];
    frm[6] = c0[15:8];
    frm[7] = c1[7:0];
    frm[8] = c1[15:8];
    frm[9] = c2[7:0];
    frm[10] = c2[15:8];
    for (int i = 0; i < 4; i++) frm[11+i] = sum[8*i +: 8];
    for (int i = 0; i < 15; i++) begin
      while ($urandom_range(99, 0) < frame_tick_pct) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, frm[i]);
    end
  endtask

  function automatic chan_t pick_extreme();
    case ($urandom_range(3, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  task automatic send_random_frame();
    chan_t c0, c1, c2;
    logic [SUM_W-1:0] sum;
    int r;
    r = $urandom_range(99, 0);
    if (r < 45) c0 = {1'b0, zoom_tab[$urandom_range(NUM_ZOOM-1, 0)]};
    else if (r < 55) c0 = {1'b0, aim_pwm};
    else if (r < 65) c0 = {1'b1, zoom_tab[$urandom_range(NUM_ZOOM-1, 0)]};
    else if (r < 80) c0 = pick_extreme();
    else c0 = 16'($urandom);
    c1 = ($urandom_range(4, 0) == 0) ? pick_extreme() : 16'($urandom);
    c2 = ($urandom_range(4, 0) == 0) ? pick_extreme() : 16'($urandom);
    sum = {16'd0, c0} + {16'd0, c1} + {16'd0, c2};
    r = $urandom_range(99, 0);
    if (r < 15) sum = sum ^ (32'd1 << $urandom_range(31, 0));
    else if (r < 30) sum = $urandom;
    repeat ($urandom_range(2, 0)) send_item(OP_BYTE, 8'($urandom));
    send_setpoint_frame(c0, c1, c2, sum);
  endtask

  task automatic run_mixed_traffic(input int n);
    int stop_at;
    int k;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      k = $urandom_range(99, 0);
      if (k < 65) begin
        send_random_frame();
      end else if (k < 85) begin
        repeat ($urandom_range(12, 1)) send_item(OP_TICK, 8'($urandom));
      end else begin
        // noise, often pieces of the marker
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(1, 0) == 0)
            send_item(OP_BYTE, MARKER[WIN_W-1-8*$urandom_range(4, 0) -: 8]);
          else
            send_item(OP_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_directed_frame();
    chan_t c0;
    frame_tick_pct = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    c0 = {1'b0, zoom_tab[0]};
    send_setpoint_frame(c0, 16'hFFFF, 16'hFFFF, {16'd0, c0} + 32'h1FFFE);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h5A);
  endtask

  task automatic test_reset_table_traffic();
    send_idle_pct = 29;
    recv_idle_pct = 82;
    frame_tick_pct = 15;
    run_mixed_traffic(600);
  endtask

  task automatic test_extreme_table();
    zoom_next = '{15'd0, 15'h7FFF, 15'd1, 15'h7FFE, 15'h4000, 15'd4400, 15'd2220, 15'h2AAA};
    load_zoom_table();
    send_idle_pct = 82;
    recv_idle_pct = 29;
    run_mixed_traffic(600);
  endtask

  task automatic test_random_table();
    for (int i = 0; i < NUM_ZOOM; i++) zoom_next[i] = CFG_W'($urandom);
    load_zoom_table();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mixed_traffic(300);
  endtask

  task automatic test_close_targets();
    int v;
    wait_drain();
    for (int i = 0; i < NUM_ZOOM; i++) begin
      v = int'(slew_pwm) + i - 3;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      zoom_next[i] = CFG_W'(v);
    end
    load_zoom_table();
    frame_tick_pct = 40;
    run_mixed_traffic(250);
    frame_tick_pct = 15;
  endtask

  task automatic test_backpressure();
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    run_mixed_traffic(150);
  endtask

  initial begin
    marker_win = '0;
    collecting = 0;
    pay_idx = 0;
    for (int i = 0; i < PAY_LEN; i++) pay_bytes[i] = '0;
    for (int i = 0; i < 3; i++) held[i] = '0;
    for (int i = 0; i < NUM_ZOOM; i++) zoom_tab[i] = ZOOM_RESET[i][CFG_W-1:0];
    aim_pwm = POS_RESET[OUT_PWM_W-1:0];
    slew_pwm = POS_RESET[OUT_PWM_W-1:0];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frame();
    test_reset_table_traffic();
    test_extreme_table();
    test_random_table();
    test_close_targets();
    test_backpressure();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
